// ----- hdl/modbus_rtu_slave_frame_engine_assert.svh -----
// Assertion macros for the frame engine checkers.
`ifndef MODBUS_RTU_SLAVE_FRAME_ENGINE_ASSERT_SVH
`define MODBUS_RTU_SLAVE_FRAME_ENGINE_ASSERT_SVH

// Same-cycle implication, idle during reset.
`define MRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, idle during reset.
`define MRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mrs_pkg.sv -----
package mrs_pkg;

  localparam int FRAME_BYTES = 256;
  localparam int STORE_WORDS = 256;
  localparam int MAX_REGS    = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  EXC_FLAG = 8'h80;

  // operation codes
  localparam logic [1:0] OP_RX_BYTE  = 2'd0;
  localparam logic [1:0] OP_LOCAL_WR = 2'd1;
  localparam logic [1:0] OP_LOCAL_RD = 2'd2;

  // function codes
  localparam logic [7:0] FN_READ_HOLD  = 8'h03;
  localparam logic [7:0] FN_READ_INPUT = 8'h04;
  localparam logic [7:0] FN_WRITE_ONE  = 8'h06;
  localparam logic [7:0] FN_WRITE_MANY = 8'h10;

  // exception codes
  localparam logic [7:0] EXC_BAD_ADDR = 8'd1;
  localparam logic [7:0] EXC_BAD_FN   = 8'd8;

  // frame status codes
  localparam logic [2:0] ST_SERVED    = 3'd0;
  localparam logic [2:0] ST_DROP      = 3'd1;
  localparam logic [2:0] ST_OTHER     = 3'd2;
  localparam logic [2:0] ST_COUNT_BAD = 3'd3;
  localparam logic [2:0] ST_EXCEPTION = 3'd4;
  localparam logic [2:0] ST_BCAST     = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_SLAVE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_REG_BASE      = 2'd1;
  localparam logic [1:0] CFG_REG_COUNT     = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  rx_byte;
    logic        frame_end;
    logic [7:0]  local_index;
    logic [15:0] local_value;
  } in_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [2:0]  frame_status;
    logic [15:0] local_data;
  } out_t;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [15:0] reg_base;
    logic [8:0]  reg_count;
  } cfg_t;

  typedef enum logic [1:0] {CMD_BYTE, CMD_LWR, CMD_LRD} cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  rx_byte;
    logic        frame_end;
    logic [7:0]  local_index;
    logic [15:0] local_value;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RD_SCAN, S_WR_CHK, S_WR_HI, S_WR_LO,
    S_TX, S_FETCH, S_FETCH_W, S_LRD_W, S_SINGLE
  } bstate_t;

  typedef enum logic [1:0] {RK_READ, RK_ECHO, RK_EXC} reply_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] idx;
  } map_t;

  // one byte through the reflected CRC-16
  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // bus register address to store entry
  function automatic map_t map_reg(input logic [15:0] a, input logic [15:0] base,
                                   input logic [8:0] count);
    map_t        m;
    logic [15:0] off;
    off   = a - base;
    m.hit = (a >= base) && ({7'd0, off} < {14'd0, count})
            && ({16'd0, off} < 32'(STORE_WORDS));
    m.idx = off[7:0];
    return m;
  endfunction

endpackage

// ----- hdl/mrs_front.sv -----
module mrs_front
  import mrs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic q_valid,
  input  logic q_pop,
  output cmd_t q_cmd
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          accept, push, pop;
  cmd_t          cmd;

  assign in_stall = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_cmd    = mem[rp_r];
  assign pop      = q_pop && q_valid;

  // classify the beat; unused operation codes are taken and dropped
  always_comb begin
    cmd.rx_byte     = in_data.rx_byte;
    cmd.frame_end   = in_data.frame_end;
    cmd.local_index = in_data.local_index;
    cmd.local_value = in_data.local_value;
    push            = accept;
    case (in_data.operation)
      OP_RX_BYTE:  cmd.kind = CMD_BYTE;
      OP_LOCAL_WR: cmd.kind = CMD_LWR;
      OP_LOCAL_RD: cmd.kind = CMD_LRD;
      default: begin
        cmd.kind = CMD_BYTE;
        push     = 1'b0;
      end
    endcase
  end

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + {{PW{1'b0}}, push} - {{PW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= cmd;
  end

endmodule

// ----- hdl/mrs_back.sv -----
module mrs_back
  import mrs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic q_valid,
  output logic q_pop,
  input  cmd_t q_cmd,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // memories
  logic [7:0]  fb_mem [FRAME_BYTES];
  logic [15:0] st_mem [STORE_WORDS];
  logic [STORE_WORDS-1:0] vld_r;
  logic        fb_we, st_we;
  logic [7:0]  fb_waddr, fb_wdata, fb_raddr, fb_q_r;
  logic [7:0]  st_waddr, st_raddr;
  logic [15:0] st_wdata, st_q_r;
  logic        st_vq_r;

  bstate_t     state_r, state_nxt;
  logic [8:0]  cnt_r, cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  hdr_r [7];
  logic [7:0]  hdr_nxt [7];
  logic [7:0]  i_r, i_nxt;
  logic [4:0]  n_r, n_nxt;
  reply_t      rk_r, rk_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [5:0]  k_r, k_nxt;
  logic [15:0] txcrc_r, txcrc_nxt;
  logic [15:0] word_r, word_nxt;
  logic        wok_r, wok_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [2:0]  stat_r, stat_nxt;
  logic        ov_r, ov_nxt;
  out_t        od_r, od_nxt;

  logic [15:0] start, qty;
  logic [7:0]  fn;
  logic        bcast, out_free, go_single, go_tx;
  logic [5:0]  rl;
  logic [7:0]  tx_b;
  logic        tx_data_k;
  map_t        m_start, m_i, m_k;
  logic [4:0]  word_j;
  logic [8:0]  fb_a9;

  assign fn       = hdr_r[1];
  assign start    = {hdr_r[2], hdr_r[3]};
  assign qty      = {hdr_r[4], hdr_r[5]};
  assign bcast    = (hdr_r[0] == 8'd0);
  assign out_free = !ov_r || !out_stall;
  assign rl       = (rk_r == RK_READ) ? 6'd3 + {n_r, 1'b0} : (rk_r == RK_ECHO) ? 6'd6 : 6'd3;
  assign word_j   = 5'(({1'b0, k_r} - 7'd3) >> 1);
  assign m_start  = map_reg(start, cfg.reg_base, cfg.reg_count);
  assign m_i      = map_reg(start + {8'd0, i_r}, cfg.reg_base, cfg.reg_count);
  assign m_k      = map_reg(start + {11'd0, word_j}, cfg.reg_base, cfg.reg_count);
  assign tx_data_k = (rk_r == RK_READ) && (k_r >= 6'd3) && (k_r < rl);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  // reply byte for position k
  always_comb begin
    tx_b = 8'd0;
    if (k_r == rl) tx_b = txcrc_r[7:0];
    else if (k_r > rl) tx_b = txcrc_r[15:8];
    else if (k_r == 6'd0) tx_b = cfg.slave_address;
    else begin
      case (rk_r)
        RK_READ: begin
          if (k_r == 6'd1) tx_b = fn;
          else if (k_r == 6'd2) tx_b = {2'b00, n_r, 1'b0};
          else tx_b = k_r[0] ? word_r[15:8] : word_r[7:0];
        end
        RK_ECHO: tx_b = hdr_r[3'(k_r)];
        RK_EXC:  tx_b = (k_r == 6'd1) ? (fn | EXC_FLAG) : code_r;
        default: tx_b = 8'd0;
      endcase
    end
  end

  // frame outcome decision, used by the next-state logic
  always_comb begin
    go_single = 1'b0;
    go_tx     = 1'b0;
    case (state_r)
      S_CHECK: begin
        if (cnt_r > 9'(FRAME_BYTES) || cnt_r < 9'd8 || crc_r != 16'd0) go_single = 1'b1;
        else if (!bcast && hdr_r[0] != cfg.slave_address) go_single = 1'b1;
        else if (fn == FN_READ_HOLD || fn == FN_READ_INPUT) go_single = bcast;
        else if (fn == FN_WRITE_MANY) begin
          go_single = ({qty, 1'b0} != {9'd0, hdr_r[6]})
                      || ({1'b0, hdr_r[6]} + 9'd9 > cnt_r);
        end else begin
          go_single = bcast;
          go_tx     = !bcast;
        end
      end
      S_RD_SCAN: go_tx = ({3'd0, n_r} == i_r) || !m_i.hit;
      S_WR_CHK: begin
        if ({8'd0, i_r} == qty || !m_i.hit) begin
          go_single = bcast;
          go_tx     = !bcast;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          case (q_cmd.kind)
            CMD_BYTE: state_nxt = q_cmd.frame_end ? S_CHECK : S_IDLE;
            CMD_LRD:  state_nxt = S_LRD_W;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_CHECK: begin
        if (go_single) state_nxt = S_SINGLE;
        else if (go_tx) state_nxt = S_TX;
        else if (fn == FN_WRITE_MANY) state_nxt = S_WR_CHK;
        else state_nxt = S_RD_SCAN;
      end
      S_RD_SCAN: if (go_tx) state_nxt = S_TX;
      S_WR_CHK: begin
        if (go_single) state_nxt = S_SINGLE;
        else if (go_tx) state_nxt = S_TX;
        else state_nxt = S_WR_HI;
      end
      S_WR_HI:   state_nxt = S_WR_LO;
      S_WR_LO:   state_nxt = S_WR_CHK;
      S_TX: begin
        if (tx_data_k && k_r[0] && !wok_r) state_nxt = S_FETCH;
        else if (out_free && k_r == rl + 6'd1) state_nxt = S_IDLE;
      end
      S_FETCH:   state_nxt = S_FETCH_W;
      S_FETCH_W: state_nxt = S_TX;
      S_LRD_W:   state_nxt = S_SINGLE;
      S_SINGLE:  if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    hdr_nxt   = hdr_r;
    i_nxt     = i_r;
    n_nxt     = n_r;
    rk_nxt    = rk_r;
    code_nxt  = code_r;
    k_nxt     = k_r;
    txcrc_nxt = txcrc_r;
    word_nxt  = word_r;
    wok_nxt   = wok_r;
    hi_nxt    = hi_r;
    stat_nxt  = stat_r;
    ov_nxt    = ov_r && out_stall;
    od_nxt    = od_r;
    q_pop     = 1'b0;
    fb_we     = 1'b0;
    fb_waddr  = cnt_r[7:0];
    fb_wdata  = q_cmd.rx_byte;
    fb_raddr  = 8'd0;
    fb_a9     = 9'd0;
    st_we     = 1'b0;
    st_waddr  = q_cmd.local_index;
    st_wdata  = q_cmd.local_value;
    st_raddr  = q_cmd.local_index;
    case (state_r)
      S_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          case (q_cmd.kind)
            CMD_BYTE: begin
              if (cnt_r < 9'(FRAME_BYTES)) begin
                fb_we   = 1'b1;
                crc_nxt = crc_feed(crc_r, q_cmd.rx_byte);
                cnt_nxt = cnt_r + 9'd1;
                if (cnt_r < 9'd7) hdr_nxt[3'(cnt_r)] = q_cmd.rx_byte;
              end else begin
                cnt_nxt = 9'(FRAME_BYTES + 1);
              end
            end
            CMD_LWR: st_we = 1'b1;
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        cnt_nxt   = 9'd0;
        crc_nxt   = CRC_INIT;
        i_nxt     = 8'd0;
        k_nxt     = 6'd0;
        txcrc_nxt = CRC_INIT;
        wok_nxt   = 1'b0;
        word_nxt  = 16'd0;
        rk_nxt    = RK_READ;
        n_nxt     = (qty > 16'(MAX_REGS)) ? 5'd0 : qty[4:0];
        if (cnt_r > 9'(FRAME_BYTES) || cnt_r < 9'd8 || crc_r != 16'd0) stat_nxt = ST_DROP;
        else if (!bcast && hdr_r[0] != cfg.slave_address) stat_nxt = ST_OTHER;
        else if (fn == FN_READ_HOLD || fn == FN_READ_INPUT) stat_nxt = ST_BCAST;
        else if (fn == FN_WRITE_MANY) begin
          if ({qty, 1'b0} != {9'd0, hdr_r[6]}) stat_nxt = ST_COUNT_BAD;
          else if ({1'b0, hdr_r[6]} + 9'd9 > cnt_r) stat_nxt = ST_DROP;
          else stat_nxt = ST_BCAST;
        end else if (fn == FN_WRITE_ONE) begin
          stat_nxt = ST_BCAST;
          if (m_start.hit) begin
            st_we    = 1'b1;
            st_waddr = m_start.idx;
            st_wdata = qty;
            rk_nxt   = RK_ECHO;
          end else begin
            rk_nxt   = RK_EXC;
            code_nxt = EXC_BAD_ADDR;
          end
        end else begin
          stat_nxt = ST_BCAST;
          rk_nxt   = RK_EXC;
          code_nxt = EXC_BAD_FN;
        end
      end
      S_RD_SCAN: begin
        if ({3'd0, n_r} != i_r) begin
          if (!m_i.hit) begin
            rk_nxt   = RK_EXC;
            code_nxt = EXC_BAD_ADDR;
          end else i_nxt = i_r + 8'd1;
        end
      end
      S_WR_CHK: begin
        if ({8'd0, i_r} == qty) rk_nxt = RK_ECHO;
        else if (!m_i.hit) begin
          rk_nxt   = RK_EXC;
          code_nxt = EXC_BAD_ADDR;
        end else begin
          fb_a9    = 9'd7 + {i_r, 1'b0};
          fb_raddr = fb_a9[7:0];
        end
      end
      S_WR_HI: begin
        hi_nxt   = fb_q_r;
        fb_a9    = 9'd8 + {i_r, 1'b0};
        fb_raddr = fb_a9[7:0];
      end
      S_WR_LO: begin
        st_we    = 1'b1;
        st_waddr = m_i.idx;
        st_wdata = {hi_r, fb_q_r};
        i_nxt    = i_r + 8'd1;
      end
      S_TX: begin
        if (!(tx_data_k && k_r[0] && !wok_r) && out_free) begin
          ov_nxt              = 1'b1;
          od_nxt.tx_valid     = 1'b1;
          od_nxt.tx_byte      = tx_b;
          od_nxt.tx_last      = (k_r == rl + 6'd1);
          od_nxt.frame_status = (rk_r == RK_EXC) ? ST_EXCEPTION : ST_SERVED;
          od_nxt.local_data   = 16'd0;
          k_nxt               = k_r + 6'd1;
          if (k_r < rl) txcrc_nxt = crc_feed(txcrc_r, tx_b);
          if (tx_data_k && !k_r[0]) wok_nxt = 1'b0;
        end
      end
      S_FETCH:   st_raddr = m_k.idx;
      S_FETCH_W: begin
        word_nxt = st_vq_r ? st_q_r : 16'd0;
        wok_nxt  = 1'b1;
      end
      S_LRD_W: begin
        word_nxt = st_vq_r ? st_q_r : 16'd0;
        stat_nxt = ST_SERVED;
      end
      S_SINGLE: begin
        if (out_free) begin
          ov_nxt              = 1'b1;
          od_nxt.tx_valid     = 1'b0;
          od_nxt.tx_byte      = 8'd0;
          od_nxt.tx_last      = 1'b1;
          od_nxt.frame_status = stat_r;
          od_nxt.local_data   = word_r;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 9'd0;
      crc_r   <= CRC_INIT;
      ov_r    <= 1'b0;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      ov_r    <= ov_nxt;
      if (st_we) vld_r[st_waddr] <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hdr_r   <= hdr_nxt;
    i_r     <= i_nxt;
    n_r     <= n_nxt;
    rk_r    <= rk_nxt;
    code_r  <= code_nxt;
    k_r     <= k_nxt;
    txcrc_r <= txcrc_nxt;
    word_r  <= word_nxt;
    wok_r   <= wok_nxt;
    hi_r    <= hi_nxt;
    stat_r  <= stat_nxt;
    od_r    <= od_nxt;
  end

  // frame buffer
  always_ff @(posedge clk) begin
    if (fb_we) fb_mem[fb_waddr] <= fb_wdata;
    fb_q_r <= fb_mem[fb_raddr];
  end

  // register store; unwritten entries read as zero via vld_r
  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    st_q_r  <= st_mem[st_raddr];
    st_vq_r <= vld_r[st_raddr];
  end

endmodule

// ----- hdl/modbus_rtu_slave_frame_engine.sv -----
// Modbus RTU slave frame engine.
// Input channel (in_valid/in_stall/in_data): one beat per serial byte, local
// store write or local store read. Bytes are buffered until the beat that
// carries frame_end; the frame is then checked (length, CRC-16, station) and
// served against a 256-entry register store.
// Result channel (out_valid/out_stall/out_data): reply bytes of a served or
// exception frame, one beat each, tx_last on the final CRC byte; any other
// frame outcome and a local read give one beat with tx_valid low.
// A byte or local write is handled as it leaves the queue; a local read waits
// for the store in S_LRD_W. At frame end the engine checks the frame, scans
// each read register, reads each written register through the frame buffer
// read port, then sends the reply bytes and fetches each read register from
// the store; a full-length multi-write carries 123 registers.
// A 4-entry command queue keeps taking beats while a reply drains.
// Reset: synchronous, active low; store reads as zero, config returns to
// address 1, base 0, count 256. When out_stall is high the current result
// holds and the engine waits; the queue fills and then raises in_stall.
// Configuration writes (cfg_we) take effect on the next edge.
module modbus_rtu_slave_frame_engine
  import mrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t cfg_r, cfg_nxt;
  logic q_valid, q_pop;
  cmd_t q_cmd;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SLAVE_ADDRESS: cfg_nxt.slave_address = cfg_wdata[7:0];
        CFG_REG_BASE:      cfg_nxt.reg_base      = cfg_wdata;
        CFG_REG_COUNT:     cfg_nxt.reg_count     = cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slave_address <= 8'd1;
      cfg_r.reg_base      <= 16'd0;
      cfg_r.reg_count     <= 9'(STORE_WORDS);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mrs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd)
  );

  mrs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/mrs_checker.sv -----
`include "modbus_rtu_slave_frame_engine_assert.svh"

module mrs_checker
  import mrs_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // a stalled result beat holds
  `MRS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // status-only results stand alone and carry no byte
  `MRS_ASSERT_IMP(a_single_last, out_valid && !out_data.tx_valid, out_data.tx_last && out_data.tx_byte == 8'd0, "status result malformed")

  // reply bytes come only from served or exception frames
  `MRS_ASSERT_IMP(a_reply_status, out_valid && out_data.tx_valid, (out_data.frame_status == ST_SERVED || out_data.frame_status == ST_EXCEPTION) && out_data.local_data == 16'd0, "reply byte with bad status")

  // status stays constant within one reply
  `MRS_ASSERT_NXT(a_reply_status_same, out_valid && !out_stall && out_data.tx_valid && !out_data.tx_last, !out_valid || (out_data.tx_valid && $stable(out_data.frame_status)), "status changed inside reply")

endmodule

bind modbus_rtu_slave_frame_engine mrs_checker u_mrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- tb/sv/modbus_rtu_slave_frame_engine_tb.sv -----
module modbus_rtu_slave_frame_engine_tb;
  import mrs_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         IDLE_LIMIT = 4000;
  localparam int         SETTLE     = 200;
  localparam int         HOLD_LEN   = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_SLAVE_ADDRESS;
  logic [15:0] cfg_wdata = '0;

  modbus_rtu_slave_frame_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // slave mirror: frame collector, store and register settings
  bit [7:0]    rx_buf [FRAME_BYTES];
  int unsigned rx_len;
  bit [15:0]   rx_crc;
  bit [15:0]   reg_mem [STORE_WORDS];
  bit [7:0]    own_addr;
  bit [15:0]   win_base;
  bit [8:0]    win_count;

  out_t      reply_q [$];   // results of the beat being modeled
  out_t      pending_q [$]; // results still owed by the block
  bit [7:0]  frame_q [$];   // request frame under construction
  int        errors;
  int        beats_sent;
  bit        no_gaps;
  bit        hold_req;

  function automatic bit [15:0] crc16_next(bit [15:0] c, bit [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function automatic bit window_hit(int unsigned a, output int unsigned idx);
    int unsigned off;
    if (a < win_base) return 1'b0;
    off = a - win_base;
    if (off >= win_count || off >= STORE_WORDS) return 1'b0;
    idx = off;
    return 1'b1;
  endfunction

  function automatic void reply_status(bit [2:0] st);
    reply_q.push_back(out_t'{1'b0, 8'h00, 1'b1, st, 16'h0000});
  endfunction

  // frame checks and service, results into reply_q
  function automatic void serve_request(int unsigned len);
    bit [7:0]    rep [40];
    int unsigned rl, fn, start, qty, n, l, idx;
    bit [15:0]   c;
    bit          exc;
    bit [7:0]    code;
    bit [2:0]    st;
    rl = 0; exc = 1'b0; code = '0; st = ST_SERVED;
    if (len > FRAME_BYTES || len < 8 || rx_crc != 16'h0000) begin
      reply_status(ST_DROP);
      return;
    end
    if (rx_buf[0] != 8'h00 && rx_buf[0] != own_addr) begin
      reply_status(ST_OTHER);
      return;
    end
    fn    = rx_buf[1];
    start = {rx_buf[2], rx_buf[3]};
    qty   = {rx_buf[4], rx_buf[5]};
    if (fn == FN_READ_HOLD || fn == FN_READ_INPUT) begin
      n = (qty > MAX_REGS) ? 0 : qty;
      rep[0] = own_addr; rep[1] = fn[7:0]; rep[2] = 8'(2 * n);
      for (int unsigned i = 0; i < n && !exc; i++) begin
        if (!window_hit((start + i) & 16'hFFFF, idx)) begin
          exc = 1'b1; code = EXC_BAD_ADDR;
        end else begin
          rep[3 + 2 * i] = reg_mem[idx][15:8];
          rep[4 + 2 * i] = reg_mem[idx][7:0];
        end
      end
      rl = 3 + 2 * n;
    end else if (fn == FN_WRITE_ONE) begin
      if (!window_hit(start, idx)) begin
        exc = 1'b1; code = EXC_BAD_ADDR;
      end else begin
        reg_mem[idx] = qty[15:0];
        rep[0] = own_addr;
        for (int i = 1; i < 6; i++) rep[i] = rx_buf[i];
        rl = 6;
      end
    end else if (fn == FN_WRITE_MANY) begin
      l = rx_buf[6];
      if (qty * 2 != l) begin
        reply_status(ST_COUNT_BAD);
        return;
      end
      if (9 + l > len) begin
        reply_status(ST_DROP);
        return;
      end
      for (int unsigned i = 0; i < qty && !exc; i++) begin
        if (!window_hit((start + i) & 16'hFFFF, idx)) begin
          exc = 1'b1; code = EXC_BAD_ADDR;
        end else begin
          reg_mem[idx] = {rx_buf[7 + 2 * i], rx_buf[8 + 2 * i]};
        end
      end
      rep[0] = own_addr;
      for (int i = 1; i < 6; i++) rep[i] = rx_buf[i];
      rl = 6;
    end else begin
      exc = 1'b1; code = EXC_BAD_FN;
    end
    if (exc) begin
      rep[0] = own_addr; rep[1] = fn[7:0] | EXC_FLAG; rep[2] = code;
      rl = 3; st = ST_EXCEPTION;
    end
    if (rx_buf[0] == 8'h00) begin
      reply_status(ST_BCAST);
      return;
    end
    c = 16'hFFFF;
    for (int unsigned i = 0; i < rl; i++) c = crc16_next(c, rep[i]);
    rep[rl] = c[7:0]; rep[rl + 1] = c[15:8];
    rl += 2;
    for (int unsigned i = 0; i < rl; i++)
      reply_q.push_back(out_t'{1'b1, rep[i], (i == rl - 1), st, 16'h0000});
  endfunction

  // one accepted beat through the mirror
  function automatic void slave_step(in_t it);
    reply_q.delete();
    case (it.operation)
      OP_RX_BYTE: begin
        if (rx_len < FRAME_BYTES) begin
          rx_buf[rx_len] = it.rx_byte;
          rx_crc = crc16_next(rx_crc, it.rx_byte);
          rx_len++;
        end else begin
          rx_len = FRAME_BYTES + 1;
        end
        if (it.frame_end) begin
          serve_request(rx_len);
          rx_len = 0;
          rx_crc = 16'hFFFF;
        end
      end
      OP_LOCAL_WR: reg_mem[it.local_index] = it.local_value;
      OP_LOCAL_RD: reply_q.push_back(out_t'{1'b0, 8'h00, 1'b1, ST_SERVED,
                                            reg_mem[it.local_index]});
      default: ;
    endcase
  endfunction

  function automatic in_t mk_beat(bit [1:0] op, bit [7:0] b, bit fe,
                                  bit [7:0] li, bit [15:0] lv);
    return in_t'{op, b, fe, li, lv};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // offer one beat, wait for it to be taken, then book its results
  task automatic send_beat(in_t it, bit typed, out_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    slave_step(it);
    if (typed) pending_q.push_back(want);
    else foreach (reply_q[i]) pending_q.push_back(reply_q[i]);
    beats_sent++;
  endtask

  task automatic send_plain(in_t it);
    send_beat(it, 1'b0, '0);
  endtask

  task automatic seal_frame();
    bit [15:0] c;
    c = 16'hFFFF;
    foreach (frame_q[i]) c = crc16_next(c, frame_q[i]);
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
  endtask

  // frame bytes as beats, unrelated fields filled with noise, an occasional local read mixed in
  task automatic send_frame();
    no_gaps = ($urandom_range(0, 3) == 0);
    foreach (frame_q[i]) begin
      if ($urandom_range(0, 19) == 0)
        send_plain(mk_beat(OP_LOCAL_RD, 8'($urandom), 1'b0, 8'($urandom),
                           16'($urandom)));
      send_plain(mk_beat(OP_RX_BYTE, frame_q[i], (i == frame_q.size() - 1),
                         8'($urandom), 16'($urandom)));
    end
    no_gaps = 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(bit [7:0] addr, bit [15:0] base, bit [8:0] count);
    drain();
    cfg_we <= 1'b1; cfg_index <= CFG_SLAVE_ADDRESS; cfg_wdata <= {8'h00, addr};
    @(posedge clk);
    cfg_index <= CFG_REG_BASE; cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= CFG_REG_COUNT; cfg_wdata <= {7'h00, count};
    @(posedge clk);
    cfg_we <= 1'b0;
    own_addr = addr; win_base = base; win_count = count;
  endtask

  function automatic bit [15:0] pick_start();
    return 16'(win_base + $urandom_range(0, win_count + 3) - 2);
  endfunction

  // one random request frame of a random kind
  task automatic random_frame();
    int        k, q;
    bit [7:0]  a, fn;
    bit [15:0] start;
    k = $urandom_range(0, 99);
    q = $urandom_range(0, 99);
    if (q < 85) a = own_addr;
    else if (q < 93) a = 8'h00;
    else begin
      a = 8'($urandom_range(1, 255));
      if (a == own_addr) a = a ^ 8'h80;
    end
    start = pick_start();
    frame_q.delete();
    if (k < 35) begin
      fn = ($urandom_range(0, 1) != 0) ? FN_READ_HOLD : FN_READ_INPUT;
      q  = ($urandom_range(0, 9) != 0) ? $urandom_range(0, MAX_REGS + 1)
                                        : $urandom_range(MAX_REGS + 1, 65535);
      frame_q = '{a, fn, start[15:8], start[7:0], q[15:8], q[7:0]};
    end else if (k < 55) begin
      q = $urandom_range(0, 65535);
      frame_q = '{a, FN_WRITE_ONE, start[15:8], start[7:0], q[15:8], q[7:0]};
    end else if (k < 84) begin
      q = $urandom_range(0, 8);
      frame_q = '{a, FN_WRITE_MANY, start[15:8], start[7:0], 8'h00, q[7:0]};
      if (k < 75) begin
        frame_q.push_back(8'(2 * q));
        repeat (2 * q) frame_q.push_back(8'($urandom));
      end else if (k < 80) begin
        // byte count disagrees with quantity
        frame_q.push_back(8'(2 * q + $urandom_range(1, 40)));
        repeat (2 * q) frame_q.push_back(8'($urandom));
      end else begin
        // data cut short of the declared byte count
        frame_q[5] = 8'd4;
        frame_q.push_back(8'd8);
        repeat (2) frame_q.push_back(8'($urandom));
      end
    end else if (k < 89) begin
      do fn = 8'($urandom); while (fn == FN_READ_HOLD || fn == FN_READ_INPUT ||
                                   fn == FN_WRITE_ONE || fn == FN_WRITE_MANY);
      frame_q = '{a, fn, start[15:8], start[7:0], 8'($urandom), 8'($urandom)};
    end else if (k < 93) begin
      frame_q = '{a, FN_READ_HOLD, start[15:8], start[7:0], 8'h00, 8'h02};
      seal_frame();
      q = $urandom_range(0, 7);
      frame_q[q] = frame_q[q] ^ (8'h01 << $urandom_range(0, 7));
      send_frame();
      return;
    end else begin
      // runt or garbage frame
      q = (k < 97) ? $urandom_range(1, 7) : $urandom_range(8, 20);
      repeat (q) frame_q.push_back(8'($urandom));
      send_frame();
      return;
    end
    seal_frame();
    send_frame();
  endtask

  task automatic random_phase(int beats);
    int r, stop;
    stop = beats_sent + beats;
    while (beats_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 10)
        send_plain(mk_beat(OP_LOCAL_WR, 8'($urandom), 1'($urandom), 8'($urandom),
                           16'($urandom)));
      else if (r < 20)
        send_plain(mk_beat(OP_LOCAL_RD, 8'($urandom), 1'($urandom), 8'($urandom),
                           16'($urandom)));
      else if (r < 22)
        send_plain(mk_beat(OP_UNUSED, 8'($urandom), 1'($urandom), 8'($urandom),
                           16'($urandom)));
      else random_frame();
    end
  endtask

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } vec_row_t;

  vec_row_t vec_tab [$];

  function automatic void add_row(in_t it, bit typed, out_t want);
    vec_tab.push_back('{it, typed, want});
  endfunction

  function automatic void add_frame_rows(bit typed, out_t want);
    bit [15:0] c;
    c = 16'hFFFF;
    foreach (frame_q[i]) c = crc16_next(c, frame_q[i]);
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
    foreach (frame_q[i])
      add_row(mk_beat(OP_RX_BYTE, frame_q[i], (i == frame_q.size() - 1), 8'h00, 16'h0000),
              typed && (i == frame_q.size() - 1), want);
  endfunction

  // main sequence
  initial begin
    rx_len = 0; rx_crc = 16'hFFFF;
    foreach (reg_mem[i]) reg_mem[i] = '0;
    own_addr = 8'd1; win_base = 16'd0; win_count = 9'd256;
    errors = 0; beats_sent = 0; no_gaps = 1'b0; hold_req = 1'b0;

    // directed vectors: store edges, unused code, runt, bad function, broadcast
    add_row(mk_beat(OP_LOCAL_RD, 8'h00, 1'b0, 8'h00, 16'h0000), 1'b1,
            out_t'{1'b0, 8'h00, 1'b1, ST_SERVED, 16'h0000});
    add_row(mk_beat(OP_LOCAL_WR, 8'h00, 1'b0, 8'hFF, 16'hFFFF), 1'b0, '0);
    add_row(mk_beat(OP_LOCAL_RD, 8'h00, 1'b0, 8'hFF, 16'h0000), 1'b1,
            out_t'{1'b0, 8'h00, 1'b1, ST_SERVED, 16'hFFFF});
    add_row(mk_beat(OP_UNUSED, 8'hFF, 1'b1, 8'hFF, 16'hFFFF), 1'b0, '0);
    add_row(mk_beat(OP_RX_BYTE, 8'hFF, 1'b1, 8'hFF, 16'hFFFF), 1'b1,
            out_t'{1'b0, 8'h00, 1'b1, ST_DROP, 16'h0000});
    frame_q = '{8'h01, 8'h2B, 8'h00, 8'h00, 8'h00, 8'h01};
    add_frame_rows(1'b0, '0);
    frame_q = '{8'h00, FN_WRITE_ONE, 8'h00, 8'hFF, 8'hAB, 8'hCD};
    add_frame_rows(1'b1, out_t'{1'b0, 8'h00, 1'b1, ST_BCAST, 16'h0000});
    add_row(mk_beat(OP_LOCAL_RD, 8'h00, 1'b0, 8'hFF, 16'h0000), 1'b1,
            out_t'{1'b0, 8'h00, 1'b1, ST_SERVED, 16'hABCD});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vec_tab[i]) send_beat(vec_tab[i].item, vec_tab[i].typed, vec_tab[i].want);
    random_phase(60);

    // window at the top of the address space, ending at the last bus address, receiver held off
    write_cfg(8'd247, 16'hFFF8, 9'd256);
    hold_req = 1'b1;
    random_phase(70);

    // empty window: every register access is refused
    write_cfg(8'h55, 16'd100, 9'd0);
    random_phase(45);

    // one-entry window at the last bus address
    write_cfg(8'd1, 16'hFFFF, 9'd1);
    random_phase(50);

    write_cfg(8'h2A, 16'h0200, 9'd37);
    random_phase(70);

    drain();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // result side back-pressure
  initial begin
    int r;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_stall <= 1'b0;
          @(posedge clk);
        end else if (r < 60) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(30, 120)) @(posedge clk);
        end else if (r < 92) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat valid=%0b byte=%02h last=%0b st=%0d data=%04h",
                 $time, out_data.tx_valid, out_data.tx_byte, out_data.tx_last,
                 out_data.frame_status, out_data.local_data);
      end else begin
        want = pending_q.pop_front();
        if (out_data !== want) begin
          errors++;
          $display("%0t: mismatch exp valid=%0b byte=%02h last=%0b st=%0d data=%04h",
                   $time, want.tx_valid, want.tx_byte, want.tx_last,
                   want.frame_status, want.local_data);
          $display("%0t:          got valid=%0b byte=%02h last=%0b st=%0d data=%04h",
                   $time, out_data.tx_valid, out_data.tx_byte, out_data.tx_last,
                   out_data.frame_status, out_data.local_data);
        end
      end
    end
  end

  // watchdog on cycles without any beat moving
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule
